// File: rtl/core/simplex_noise_eval_macros.svh
// Assertion helpers for the simplex noise evaluator
`ifndef SIMPLEX_NOISE_EVAL_MACROS_SVH
`define SIMPLEX_NOISE_EVAL_MACROS_SVH
`ifndef SYNTHESIS
`define SNE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SNE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SNE_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SNE_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: rtl/core/sne_pkg.sv
`default_nettype none
package sne_pkg;
	localparam int DIMS_DEF   = 2;
	localparam int FRAC_DEF   = 16;
	localparam int MAX_DIMS   = 4;
	localparam int PERM_SIZE  = 256;
	localparam int PERM_AW    = 8;
	localparam int COORD_W    = 32;
	localparam int SCALE_W    = 16;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd27034;
	localparam logic REG_SCALE = 1'b0;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                               op;
		logic [PERM_AW-1:0]                idx;
		logic [7:0]                        val;
		logic [MAX_DIMS-1:0][COORD_W-1:0]  coord;
	} item_t;

	// Q30 skew factor (sqrt(n+1)-1)/n
	function automatic logic [29:0] skew_q30(input int dims);
		logic [29:0] r;
		case (dims)
			2: r = 30'd393016785;
			3: r = 30'd357913941;
			default: r = 30'd331804471;
		endcase
		return r;
	endfunction

	// Q30 unskew factor (1-1/sqrt(n+1))/n
	function automatic logic [29:0] unskew_q30(input int dims);
		logic [29:0] r;
		case (dims)
			2: r = 30'd226908346;
			3: r = 30'd178956971;
			default: r = 30'd148387471;
		endcase
		return r;
	endfunction

	// Hash byte -> gradient, 2 bits per axis: 00 zero, 01 plus one, 11 minus one
	function automatic logic [PERM_SIZE-1:0][2*MAX_DIMS-1:0] build_grad_lut(input int dims);
		logic [31:0][2*MAX_DIMS-1:0]          gt;
		logic [PERM_SIZE-1:0][2*MAX_DIMS-1:0] lut;
		logic [2*MAX_DIMS-1:0]                v;
		int neg, m, p, row, total, zc, nc, rem, dgt, r, k, j, ngrad;
		gt = '0;
		lut = '0;
		row = 0;
		total = 1;
		for (p = 0; p < dims; p++)
			total = total * 3;
		for (neg = 0; neg < dims; neg++) begin
			for (m = 0; m < total; m++) begin
				v = '0;
				zc = 0;
				nc = 0;
				rem = m;
				for (p = dims - 1; p >= 0; p--) begin
					dgt = rem % 3;
					rem = rem / 3;
					v[2*p +: 2] = (dgt == 0) ? 2'b01 : ((dgt == 1) ? 2'b11 : 2'b00);
					if (dgt == 1) nc++;
					if (dgt == 2) zc++;
				end
				if (zc == 1 && nc == neg && row < 32) begin
					gt[row] = v;
					row++;
				end
			end
		end
		ngrad = dims * (1 << (dims - 1));
		for (k = 0; k < PERM_SIZE; k++) begin
			r = k;
			for (j = 0; j < PERM_SIZE; j++)
				if (r >= ngrad) r = r - ngrad;
			lut[k] = gt[r];
		end
		return lut;
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/simplex_noise_eval.sv
// Channel   Handshake                  Beat contents
// item      item_valid / item_ready    operation, perm_index, perm_value, coord_x..coord_w
// result    result_valid / result_ready noise_value
// config    APB psel/penable/pwrite    output_scale at byte address 0
//
// A table write is taken while the back end is idle; in an evaluate, the corner loop
// walks each hash chain through the single read port of the table.
// A two-beat queue lets items be taken while the back end is busy.
// Reset restores the identity table at once through per-entry valid bits.
// A waiting result holds in its output register; the back end stalls only when
// a second result is ready before the first is taken.
`default_nettype none
module simplex_noise_eval #(
	parameter int DIMS      = sne_pkg::DIMS_DEF,
	parameter int FRAC_BITS = sne_pkg::FRAC_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  perm_index,
	input  wire logic [7:0]  perm_value,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [31:0] coord_z,
	input  wire logic [31:0] coord_w,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [15:0]      noise_value,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [sne_pkg::SCALE_W-1:0] scale_q;
	sne_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == sne_pkg::REG_SCALE) ? {16'b0, scale_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= sne_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == sne_pkg::REG_SCALE) begin
			scale_q <= pwdata[15:0];
		end
	end

	always_comb begin
		in_item.op       = sne_pkg::op_t'(operation);
		in_item.idx      = perm_index;
		in_item.val      = perm_value;
		in_item.coord[0] = coord_x;
		in_item.coord[1] = coord_y;
		in_item.coord[2] = coord_z;
		in_item.coord[3] = coord_w;
	end

	sne_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_valid),
		.in_ready (item_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	sne_back #(
		.DIMS      (DIMS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.scale     (scale_q),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.noise     (noise_value)
	);
endmodule
`default_nettype wire

// File: rtl/core/sne_front.sv
`default_nettype none
`include "simplex_noise_eval_macros.svh"
module sne_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sne_pkg::item_t in_item,
	output logic                q_valid,
	input  wire logic           q_ready,
	output sne_pkg::item_t      q_item
);
	sne_pkg::item_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SNE_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`SNE_ASSERT_IMP(a_ptr_gap, clk, arst_n, cnt_q == 2'd1, wr_q != rd_q)
	`SNE_ASSERT_NXT(a_fill, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
endmodule
`default_nettype wire

// File: rtl/core/sne_back.sv
`default_nettype none
`include "simplex_noise_eval_macros.svh"
module sne_back #(
	parameter int DIMS      = sne_pkg::DIMS_DEF,
	parameter int FRAC_BITS = sne_pkg::FRAC_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	output logic                             q_ready,
	input  wire sne_pkg::item_t              q_item,
	input  wire logic [sne_pkg::SCALE_W-1:0] scale,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [15:0]                      noise
);
	localparam int AXW  = (DIMS > 2) ? 2 : 1;
	localparam int CIW  = $clog2(DIMS + 1);
	localparam int RKW  = $clog2(DIMS + 1);
	localparam int CW   = 36 - FRAC_BITS;
	localparam int SCW  = CW + 2;
	localparam int UMW  = SCW + 31;
	localparam int DW   = FRAC_BITS + 4;
	localparam int XW   = FRAC_BITS + 5;
	localparam int R2W  = 2 * XW + 2;
	localparam int DTW  = XW + 2;
	localparam int PRW  = 31 + DTW;
	localparam int AW   = FRAC_BITS + 34;
	localparam int N30W = AW - FRAC_BITS;
	localparam int FPW  = N30W + 17;
	localparam int TSH  = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
	localparam int TMU  = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;
	localparam logic [29:0] SKEW   = sne_pkg::skew_q30(DIMS);
	localparam logic [29:0] UNSKEW = sne_pkg::unskew_q30(DIMS);
	localparam logic [sne_pkg::PERM_SIZE-1:0][2*sne_pkg::MAX_DIMS-1:0] GRAD_LUT =
		sne_pkg::build_grad_lut(DIMS);

	typedef enum logic [4:0] {
		S_IDLE, S_MLO, S_MHI, S_SKEW, S_CELL, S_UNSK, S_DIFF, S_RANK, S_CORN,
		S_LKA, S_LKD, S_SQ, S_TSUM, S_T2, S_T4, S_PROD, S_ACC, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	logic [7:0]                  mem [sne_pkg::PERM_SIZE];
	logic [sne_pkg::PERM_SIZE-1:0] vld_q;
	logic [7:0]                  rdata_q;
	logic                        rvld_q;
	logic [7:0]                  rd_addr_q;

	logic signed [31:0]     x_q   [DIMS];
	logic signed [33:0]     sumx_q;
	logic [46:0]            plo_q;
	logic signed [47:0]     phi_q;
	logic signed [34:0]     s_q;
	logic signed [CW-1:0]   c_q   [DIMS];
	logic signed [UMW-1:0]  um_q;
	logic signed [DW-1:0]   d_q   [DIMS];
	logic [RKW-1:0]         rank_q[DIMS];
	logic [CIW-1:0]         ci_q;
	logic [30:0]            gacc_q;
	logic signed [XW-1:0]   xy_q  [DIMS];
	logic [DIMS-1:0]        off_q;
	logic [AXW-1:0]         ax_q;
	logic [7:0]             k_q;
	logic signed [2*XW-1:0] sq_q  [DIMS];
	logic [2*sne_pkg::MAX_DIMS-1:0] grad_q;
	logic                   pos_q;
	logic [29:0]            t30_q, t2_q, t4_q;
	logic signed [DTW-1:0]  dt_q;
	logic signed [PRW-1:0]  pr_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [FPW-1:0]  fp_q;
	logic                   out_valid_q;
	logic [15:0]            noise_q;

	// combinational helpers
	logic signed [33:0]     sumx_c;
	logic signed [64:0]     sprod_c;
	logic signed [35:0]     cfull_c [DIMS];
	logic signed [SCW-1:0]  sc_c;
	logic signed [UMW-1:0]  u_c;
	logic signed [63:0]     dfull_c [DIMS];
	logic [RKW-1:0]         rank_c  [DIMS];
	logic [DIMS-1:0]        off_c;
	logic [30:0]            gofs_c;
	logic signed [XW+1:0]   xyf_c   [DIMS];
	logic signed [R2W-1:0]  r2_c;
	logic signed [R2W:0]    t_c;
	logic signed [R2W+TMU:0] tsh_c;
	logic signed [DTW-1:0]  dt_c;
	logic [59:0]            sq30_c;
	logic [7:0]             lk_addr_c;
	logic signed [FPW:0]    vsum_c;
	logic signed [FPW-23:0] v_c;
	logic [15:0]            vsat_c;
	logic                   mem_we;

	always_comb begin
		logic [RKW-1:0] kk;
		logic [1:0]     gsel;
		sumx_c = '0;
		for (int j = 0; j < DIMS; j++)
			sumx_c = sumx_c + 34'($signed(q_item.coord[j]));
		sprod_c = (65'(phi_q) <<< 17) + $signed({18'b0, plo_q});
		sc_c = '0;
		for (int j = 0; j < DIMS; j++) begin
			cfull_c[j] = (36'(x_q[j]) + 36'(s_q)) >>> FRAC_BITS;
			sc_c = sc_c + SCW'(c_q[j]);
		end
		u_c = um_q >>> (30 - FRAC_BITS);
		for (int j = 0; j < DIMS; j++)
			dfull_c[j] = 64'(x_q[j]) - (64'(c_q[j]) <<< FRAC_BITS) + 64'(u_c);
		for (int i = 0; i < DIMS; i++) begin
			kk = '0;
			for (int j = 0; j < DIMS; j++)
				if (d_q[i] > d_q[j] || (i <= j && d_q[i] >= d_q[j]))
					kk = kk + RKW'(1);
			rank_c[i] = kk;
		end
		gofs_c = gacc_q >> (30 - FRAC_BITS);
		for (int j = 0; j < DIMS; j++) begin
			off_c[j] = (int'(rank_q[j]) >= DIMS + 1 - int'(ci_q));
			xyf_c[j] = (XW+2)'(d_q[j]) + $signed({1'b0, (XW+1)'(gofs_c)})
				- (off_c[j] ? ((XW+2)'(1) <<< FRAC_BITS) : '0);
		end
		r2_c = '0;
		dt_c = '0;
		for (int j = 0; j < DIMS; j++) begin
			r2_c = r2_c + R2W'(sq_q[j]);
			gsel = grad_q[2*j +: 2];
			case (gsel)
				2'b01:   dt_c = dt_c + DTW'(xy_q[j]);
				2'b11:   dt_c = dt_c - DTW'(xy_q[j]);
				default: dt_c = dt_c;
			endcase
		end
		t_c   = ((R2W+1)'(1) <<< (2 * FRAC_BITS - 1)) - (R2W+1)'(r2_c);
		tsh_c = (t_c >>> TSH) <<< TMU;
		sq30_c = (state_q == S_T2) ? (60'(t30_q) * 60'(t30_q)) : (60'(t2_q) * 60'(t2_q));
		lk_addr_c = k_q + c_q[ax_q][7:0] + 8'(off_q[ax_q]);
		vsum_c = (FPW+1)'(fp_q) + ((FPW+1)'(1) <<< 38);
		v_c    = (FPW-22)'(vsum_c >>> 23);
		if (v_c < 0)
			vsat_c = 16'd0;
		else if (v_c > $signed((FPW-22)'(65535)))
			vsat_c = 16'hFFFF;
		else
			vsat_c = v_c[15:0];
		mem_we = (state_q == S_IDLE) && q_valid && (q_item.op == sne_pkg::OP_WRITE);
	end

	assign q_ready   = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign noise     = noise_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[q_item.idx] <= q_item.val;
		if (state_q == S_LKA)
			rdata_q <= mem[lk_addr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.op == sne_pkg::OP_WRITE) begin
							vld_q[q_item.idx] <= 1'b1;
						end else begin
							for (int j = 0; j < DIMS; j++)
								x_q[j] <= $signed(q_item.coord[j]);
							sumx_q  <= sumx_c;
							state_q <= S_MLO;
						end
					end
				end
				S_MLO: begin
					plo_q   <= 47'(sumx_q[16:0]) * 47'(SKEW);
					state_q <= S_MHI;
				end
				S_MHI: begin
					phi_q   <= $signed(sumx_q[33:17]) * $signed({1'b0, SKEW});
					state_q <= S_SKEW;
				end
				S_SKEW: begin
					s_q     <= 35'(sprod_c >>> 30);
					state_q <= S_CELL;
				end
				S_CELL: begin
					for (int j = 0; j < DIMS; j++)
						c_q[j] <= cfull_c[j][CW-1:0];
					state_q <= S_UNSK;
				end
				S_UNSK: begin
					um_q    <= sc_c * $signed({1'b0, UNSKEW});
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					for (int j = 0; j < DIMS; j++)
						d_q[j] <= dfull_c[j][DW-1:0];
					state_q <= S_RANK;
				end
				S_RANK: begin
					for (int j = 0; j < DIMS; j++)
						rank_q[j] <= rank_c[j];
					ci_q    <= '0;
					gacc_q  <= '0;
					acc_q   <= '0;
					state_q <= S_CORN;
				end
				S_CORN: begin
					for (int j = 0; j < DIMS; j++)
						xy_q[j] <= xyf_c[j][XW-1:0];
					off_q   <= off_c;
					ax_q    <= AXW'(DIMS - 1);
					k_q     <= 8'd0;
					state_q <= S_LKA;
				end
				S_LKA: begin
					rd_addr_q <= lk_addr_c;
					rvld_q    <= vld_q[lk_addr_c];
					state_q   <= S_LKD;
				end
				S_LKD: begin
					// unwritten entries still hold the identity
					k_q <= rvld_q ? rdata_q : rd_addr_q;
					if (ax_q == '0) begin
						state_q <= S_SQ;
					end else begin
						ax_q    <= ax_q - AXW'(1);
						state_q <= S_LKA;
					end
				end
				S_SQ: begin
					for (int j = 0; j < DIMS; j++)
						sq_q[j] <= xy_q[j] * xy_q[j];
					grad_q  <= GRAD_LUT[k_q];
					state_q <= S_TSUM;
				end
				S_TSUM: begin
					pos_q   <= (t_c > 0);
					t30_q   <= (t_c > 0) ? tsh_c[29:0] : 30'd0;
					dt_q    <= dt_c;
					state_q <= S_T2;
				end
				S_T2: begin
					t2_q    <= sq30_c[59:30];
					state_q <= S_T4;
				end
				S_T4: begin
					t4_q    <= sq30_c[59:30];
					state_q <= S_PROD;
				end
				S_PROD: begin
					pr_q    <= $signed({1'b0, t4_q}) * dt_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (pos_q)
						acc_q <= acc_q + AW'(pr_q);
					gacc_q <= gacc_q + 31'(UNSKEW);
					if (ci_q == CIW'(DIMS)) begin
						state_q <= S_FIN;
					end else begin
						ci_q    <= ci_q + CIW'(1);
						state_q <= S_CORN;
					end
				end
				S_FIN: begin
					fp_q    <= N30W'(acc_q >>> FRAC_BITS) * $signed({1'b0, scale});
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						noise_q     <= vsat_c;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SNE_ASSERT_IMP(a_axis_range, clk, arst_n, state_q == S_LKA || state_q == S_LKD, int'(ax_q) < DIMS)
	`SNE_ASSERT_IMP(a_corner_range, clk, arst_n, state_q == S_CORN, int'(ci_q) <= DIMS)
	`SNE_ASSERT_NXT(a_result_lands, clk, arst_n, state_q == S_OUT && !out_valid_q, out_valid_q && state_q == S_IDLE)
	`SNE_ASSERT_NXT(a_write_marks, clk, arst_n, mem_we, vld_q[$past(q_item.idx)])
endmodule
`default_nettype wire

// File: tb/simplex_noise_eval_checker.sv
`default_nettype none
module simplex_noise_eval_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  perm_index,
	input  wire logic [7:0]  perm_value,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic        result_valid,
	input  wire logic        result_ready,
	input  wire logic [15:0] noise_value,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               noise_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int           NDIM    = 2;
	localparam int           FB      = 16;
	localparam int           NGRAD   = 4;
	localparam longint       SKEW2   = 64'sd393016785;
	localparam longint       UNSKEW2 = 64'sd226908346;
	localparam logic [2:0]   ADDR_SCALE = 3'(4 * sne_pkg::REG_SCALE);

	logic [7:0]  hash_tab [sne_pkg::PERM_SIZE];
	logic [15:0] scale_reg;
	logic [15:0] noise_q [$];

	// gradients for two axes: (1,0) (0,1) (-1,0) (0,-1)
	function automatic longint grad_dot(int g, longint ax, longint ay);
		case (g)
			0: return ax;
			1: return ay;
			2: return -ax;
			default: return -ay;
		endcase
	endfunction

	function automatic logic [15:0] noise_at(logic [31:0] px, logic [31:0] py);
		longint pos [NDIM];
		longint lat [NDIM];
		longint ofs [NDIM];
		longint rel [NDIM];
		int     rnk [NDIM];
		int     step [NDIM];
		longint skew, unsk, corner_sh, dist2, falloff, t30, t2, t4, acc, n30, v;
		int     h;
		pos[0] = longint'($signed(px));
		pos[1] = longint'($signed(py));
		skew = ((pos[0] + pos[1]) * SKEW2) >>> 30;
		for (int j = 0; j < NDIM; j++)
			lat[j] = (pos[j] + skew) >>> FB;
		unsk = ((lat[0] + lat[1]) * UNSKEW2) >>> (30 - FB);
		for (int j = 0; j < NDIM; j++)
			ofs[j] = pos[j] - (lat[j] <<< FB) + unsk;
		// ties: lower axis ranks higher
		for (int i = 0; i < NDIM; i++) begin
			rnk[i] = 0;
			for (int j = 0; j < NDIM; j++)
				if (ofs[i] > ofs[j] || (i <= j && ofs[i] >= ofs[j]))
					rnk[i]++;
		end
		acc = 0;
		for (int i = 0; i <= NDIM; i++) begin
			corner_sh = (longint'(i) * UNSKEW2) >>> (30 - FB);
			dist2 = 0;
			for (int j = 0; j < NDIM; j++) begin
				step[j] = (rnk[j] >= NDIM - i + 1) ? 1 : 0;
				rel[j] = ofs[j] - (longint'(step[j]) <<< FB) + corner_sh;
				dist2 += rel[j] * rel[j];
			end
			h = 0;
			for (int j = NDIM - 1; j >= 0; j--)
				h = hash_tab[8'(h + int'(lat[j][7:0]) + step[j])];
			falloff = (64'sd1 <<< (2 * FB - 1)) - dist2;
			if (falloff > 0) begin
				t30 = falloff >>> (2 * FB - 30);
				t2 = (t30 * t30) >>> 30;
				t4 = (t2 * t2) >>> 30;
				acc += t4 * grad_dot(h % NGRAD, rel[0], rel[1]);
			end
		end
		n30 = acc >>> FB;
		v = (n30 * longint'(scale_reg) + (64'sd1 <<< 38)) >>> 23;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	assign noise_pending = noise_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sne_pkg::PERM_SIZE; i++)
				hash_tab[i] = 8'(i);
			scale_reg = sne_pkg::SCALE_RESET;
			noise_q.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_SCALE)
				scale_reg = pwdata[15:0];
			if (item_valid && item_ready) begin
				if (sne_pkg::op_t'(operation) == sne_pkg::OP_WRITE)
					hash_tab[perm_index] = perm_value;
				else
					noise_q.push_back(noise_at(coord_x, coord_y));
			end
			if (result_valid && result_ready) begin
				if (noise_q.size() == 0) begin
					$error("noise_value: unexpected beat, actual %0d", noise_value);
					fail_count++;
				end else begin
					if (noise_value !== noise_q[0]) begin
						$error("noise_value: expected %0d, actual %0d",
							noise_q[0], noise_value);
						fail_count++;
					end
					void'(noise_q.pop_front());
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/tb_simplex_noise_eval.sv
`default_nettype none
module tb_simplex_noise_eval;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         QUIET_LIMIT = 5000;
	localparam int         SETTLE      = 80;
	localparam logic [2:0] ADDR_SCALE  = 3'(4 * sne_pkg::REG_SCALE);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        operation = 1'b0;
	logic [7:0]  perm_index = '0;
	logic [7:0]  perm_value = '0;
	logic [31:0] coord_x = '0, coord_y = '0, coord_z = '0, coord_w = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [15:0] noise_value;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, noise_pending;
	int send_idle = 0, recv_idle = 0;
	int quiet = 0;

	simplex_noise_eval u_dut (.*);

	simplex_noise_eval_checker u_chk (
		.clk, .arst_n, .item_valid, .item_ready, .operation, .perm_index, .perm_value,
		.coord_x, .coord_y, .result_valid, .result_ready, .noise_value,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .noise_pending
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		result_ready = ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
				quiet <= 0;
			else if (quiet + 1 >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else
				quiet <= quiet + 1;
		end
	end

	task automatic set_scale(logic [15:0] s);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = ADDR_SCALE;
		pwdata = {16'h0, s};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk iff pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic send_beat(sne_pkg::op_t op, logic [7:0] idx, logic [7:0] val,
			logic [31:0] x, logic [31:0] y);
		while ($urandom_range(99) < send_idle) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		operation = op; perm_index = idx; perm_value = val;
		coord_x = x; coord_y = y; coord_z = $urandom; coord_w = $urandom;
		@(posedge clk iff item_ready);
		@(negedge clk);
	endtask

	// wait for every result, then let any table write drain
	task automatic drain();
		item_valid = 1'b0;
		while (noise_pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
			2: return {$urandom_range(7) == 0 ? 16'hffff : 16'(int'($urandom_range(6))), 16'h0};
			default: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
		endcase
	endfunction

	initial begin
		logic [31:0] cx;
		logic [15:0] scales [3];
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, ties, integer points, table edge entries
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h0, 32'h0);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h7fffffff, 32'h7fffffff);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h80000000, 32'h80000000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h7fffffff, 32'h80000000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'hffffffff, 32'hffffffff);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00018000, 32'h00018000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00030000, 32'hfffd0000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00004000, 32'h0000c000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h0000c000, 32'h00004000);
		send_beat(sne_pkg::OP_WRITE, 8'd0, 8'd255, 0, 0);
		send_beat(sne_pkg::OP_WRITE, 8'd255, 8'd0, 0, 0);
		send_beat(sne_pkg::OP_WRITE, 8'd1, 8'd255, 0, 0);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00008000, 32'h00002000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'hffff8000, 32'hffff0000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00ff4000, 32'h00ff1000);
		drain();
		set_scale(16'd0);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00004000, 32'h00001000);
		drain();
		set_scale(16'hffff);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00004000, 32'h00001000);
		send_beat(sne_pkg::OP_EVAL, 0, 0, 32'h00012345, 32'hfff54321);

		scales[0] = 16'd27034; scales[1] = 16'd256; scales[2] = 16'($urandom);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 6 : (ph == 1) ? 75 : 0;
			recv_idle = (ph == 0) ? 75 : (ph == 1) ? 6 : 0;
			drain();
			set_scale(scales[ph]);
			for (int n = 0; n < 660; n++) begin
				if ($urandom_range(9) == 0)
					send_beat(sne_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 0, 0);
				else begin
					cx = rand_coord();
					// occasional point on the diagonal for offset ties
					send_beat(sne_pkg::OP_EVAL, 0, 0, cx,
						($urandom_range(9) == 0) ? cx : rand_coord());
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
